>>> src/cral_pkg.sv
// Package for the challenge-response authenticator with lockout.
// Holds constants, codes, payload structs and the generator and hash step functions.
// No dependencies; imported by every module of the block.
package cral_pkg;

    // Hash and generator constants
    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] GEN_SEED  = 32'h0000_ace1;

    // Defaults for the top-level parameters
    localparam int DEF_NONCE_BYTES      = 16;
    localparam int DEF_TICKS_PER_SECOND = 1000;

    // Configuration port geometry, register reset values and thresholds
    localparam int          CFG_DATA_W      = 64;
    localparam int          CFG_INDEX_W     = 3;
    localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd3;
    localparam logic [15:0] RST_TIMEOUT      = 16'd300;
    localparam logic [1:0]  RST_SEC_LEVEL    = 2'd1;
    localparam logic [1:0]  SEC_WIPE_LEVEL   = 2'd2;
    localparam logic [7:0]  FAIL_SAT         = 8'hff;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_HIGH     = 3'd0,
        REG_KEY_LOW      = 3'd1,
        REG_MAX_ATTEMPTS = 3'd2,
        REG_TIMEOUT      = 3'd3,
        REG_SEC_LEVEL    = 3'd4
    } reg_index_e;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_RESPONSE = 3'd2,
        OP_END      = 3'd3,
        OP_QUERY    = 3'd4
    } op_e;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ACTIVE       = 3'd1,
        ST_NO_CHALLENGE = 3'd2,
        ST_MISMATCH     = 3'd3,
        ST_LOCKED_OUT   = 3'd4,
        ST_NOT_AUTH     = 3'd5,
        ST_EXPIRED      = 3'd6
    } status_e;

    typedef enum logic [1:0] {
        AUTH_LOCKED    = 2'd0,
        AUTH_CHALLENGE = 2'd1,
        AUTH_OK        = 2'd2,
        AUTH_EXPIRED   = 2'd3
    } auth_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_CHECK,
        S_EXEC,
        S_DRAW,
        S_HASH,
        S_VERIFY,
        S_REPLY
    } seq_state_e;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] response;
        logic [15:0] timer_sample;
        logic [9:0]  adc_sample;
    } cral_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  auth_state;
        logic        session_active;
        logic [7:0]  failed_count;
        logic [31:0] challenge_out;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic        wipe_keys;
    } cral_out_t;

    // One generator draw: stir with the samples, then shift in the feedback bit
    function automatic logic [31:0] gen_draw(logic [31:0] g, logic [15:0] timer,
                                             logic [9:0] adc);
        logic [31:0] s;
        logic        fb;
        s  = g ^ {16'd0, timer} ^ {22'd0, adc};
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[31:1]};
    endfunction

    // One FNV-1a byte step
    function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

endpackage

>>> src/challenge_response_auth_lockout_top.sv
// Challenge-response authenticator with failure lockout and session timeout.
// Every command passes the limit, check and execute states before the reply state;
// a start that opens a session adds a draw state (one generator draw per nonce byte),
// and a challenged response adds hash and verify (one FNV byte step per cycle over
// 20 + NONCE_BYTES bytes in the shared hash unit). One word in flight; the next may be
// accepted in the done cycle. Results cannot be stalled. Reset: asynchronous,
// active low; all state but the hash accumulator resets at once, no clearing pass.
module challenge_response_auth_lockout_top
    import cral_pkg::*;
#(
    parameter int NONCE_BYTES      = DEF_NONCE_BYTES,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cral_in_t               cmd,
    output logic                   done,
    output cral_out_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int          HASH_BYTES = 20 + NONCE_BYTES;
    localparam int          HIDX_W     = $clog2(HASH_BYTES);
    localparam int          NIDX_W     = (NONCE_BYTES > 1) ? $clog2(NONCE_BYTES) : 1;
    localparam logic [31:0] TPS_W      = 32'(TICKS_PER_SECOND);

    // Configuration registers
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [7:0]  max_attempts_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  sec_level_reg;

    // Session state
    seq_state_e  state_reg;
    seq_state_e  state_next;
    cral_in_t    cmd_reg;
    logic [31:0] tick_count_reg;
    logic [31:0] start_time_reg;
    auth_e       auth_reg;
    logic        active_reg;
    logic [7:0]  fail_reg;
    logic [31:0] challenge_reg;
    logic [7:0]  nonce_reg [NONCE_BYTES];
    logic [31:0] gen_reg;
    status_e     status_reg;
    logic        wipe_reg;

    // Sequencer working registers
    logic [31:0]       limit_reg;
    logic              expired_reg;
    logic [NIDX_W-1:0] nidx_reg;
    logic [HIDX_W-1:0] hidx_reg;
    logic [31:0]       xsum_reg;

    logic              accept;
    logic              renew;
    logic [31:0]       draw_val;
    logic [7:0]        hash_byte;
    logic              hash_en;
    logic              hash_seed;
    logic [31:0]       hash_val;
    logic [31:0]       expected;
    logic [7:0]        fail_inc;
    logic [1:0]        cb_sel;
    logic [2:0]        kh_sel;
    logic [2:0]        kl_sel;
    logic [NIDX_W-1:0] hn_sel;
    logic [63:0]       nonce_hi;
    logic [63:0]       nonce_lo;

    assign accept   = start && !busy;
    assign busy     = !(state_reg == S_IDLE || state_reg == S_REPLY);
    assign draw_val = gen_draw(gen_reg, cmd_reg.timer_sample, cmd_reg.adc_sample);
    // A start proceeds unless a live session is still within its lifetime
    assign renew    = !(active_reg && !expired_reg);
    assign expected = xsum_reg ^ hash_val;
    assign fail_inc = (fail_reg != FAIL_SAT) ? fail_reg + 8'd1 : fail_reg;

    // Pick the hash byte: challenge, key, then nonce, all most significant first
    always_comb
    begin
        cb_sel = 2'(hidx_reg);
        kh_sel = 3'(hidx_reg - HIDX_W'(4));
        kl_sel = 3'(hidx_reg - HIDX_W'(12));
        hn_sel = NIDX_W'(hidx_reg - HIDX_W'(20));
        if (hidx_reg < HIDX_W'(4))
        begin
            hash_byte = challenge_reg[{~cb_sel, 3'b000} +: 8];
        end
        else if (hidx_reg < HIDX_W'(12))
        begin
            hash_byte = key_high_reg[{~kh_sel, 3'b000} +: 8];
        end
        else if (hidx_reg < HIDX_W'(20))
        begin
            hash_byte = key_low_reg[{~kl_sel, 3'b000} +: 8];
        end
        else
        begin
            hash_byte = nonce_reg[hn_sel];
        end
    end

    // Restart the hash at the head of each of the three segments
    assign hash_en   = (state_reg == S_HASH);
    assign hash_seed = (hidx_reg == HIDX_W'(0)) || (hidx_reg == HIDX_W'(4)) ||
                       (hidx_reg == HIDX_W'(20));

    cral_fnv_unit u_fnv (
        .clk  (clk),
        .en   (hash_en),
        .seed (hash_seed),
        .data (hash_byte),
        .hash (hash_val)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            max_attempts_reg <= RST_MAX_ATTEMPTS;
            timeout_reg      <= RST_TIMEOUT;
            sec_level_reg    <= RST_SEC_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH:     key_high_reg     <= cfg_data;
                REG_KEY_LOW:      key_low_reg      <= cfg_data;
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[7:0];
                REG_TIMEOUT:      timeout_reg      <= cfg_data[15:0];
                REG_SEC_LEVEL:    sec_level_reg    <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = accept ? S_LIMIT : S_IDLE;
            S_LIMIT:  state_next = S_CHECK;
            S_CHECK:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (cmd_reg.op == OP_START && renew)
                begin
                    state_next = S_DRAW;
                end
                else if (cmd_reg.op == OP_RESPONSE && auth_reg == AUTH_CHALLENGE)
                begin
                    state_next = S_HASH;
                end
                else
                begin
                    state_next = S_REPLY;
                end
            end
            S_DRAW:   state_next = (nidx_reg == NIDX_W'(NONCE_BYTES - 1)) ? S_REPLY : S_DRAW;
            S_HASH:   state_next = (hidx_reg == HIDX_W'(HASH_BYTES - 1)) ? S_VERIFY : S_HASH;
            S_VERIFY: state_next = S_REPLY;
            S_REPLY:  state_next = accept ? S_LIMIT : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Session datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= '0;
            tick_count_reg <= '0;
            start_time_reg <= '0;
            auth_reg       <= AUTH_LOCKED;
            active_reg     <= 1'b0;
            fail_reg       <= '0;
            challenge_reg  <= '0;
            gen_reg        <= GEN_SEED;
            status_reg     <= ST_OK;
            wipe_reg       <= 1'b0;
            limit_reg      <= '0;
            expired_reg    <= 1'b0;
            nidx_reg       <= '0;
            hidx_reg       <= '0;
            xsum_reg       <= '0;
            for (int i = 0; i < NONCE_BYTES; i++)
            begin
                nonce_reg[i] <= '0;
            end
        end
        else
        begin
            // Take a new command word; a tick advances time right away
            if (accept)
            begin
                cmd_reg    <= cmd;
                status_reg <= ST_OK;
                wipe_reg   <= 1'b0;
                if (cmd.op == OP_TICK)
                begin
                    tick_count_reg <= tick_count_reg + 32'd1;
                end
            end
            case (state_reg)
                S_LIMIT:
                begin
                    limit_reg <= {16'd0, timeout_reg} * TPS_W;
                end
                S_CHECK:
                begin
                    expired_reg <= (tick_count_reg - start_time_reg) >= limit_reg;
                end
                S_EXEC:
                begin
                    case (cmd_reg.op)
                        OP_TICK, OP_END:
                        begin
                            if (cmd_reg.op == OP_END || (active_reg && expired_reg))
                            begin
                                active_reg    <= 1'b0;
                                auth_reg      <= AUTH_LOCKED;
                                challenge_reg <= '0;
                                for (int i = 0; i < NONCE_BYTES; i++)
                                begin
                                    nonce_reg[i] <= '0;
                                end
                            end
                        end
                        OP_START:
                        begin
                            if (renew)
                            begin
                                gen_reg        <= draw_val;
                                challenge_reg  <= draw_val;
                                auth_reg       <= AUTH_CHALLENGE;
                                start_time_reg <= tick_count_reg;
                                fail_reg       <= '0;
                                active_reg     <= 1'b1;
                                nidx_reg       <= '0;
                            end
                            else
                            begin
                                status_reg <= ST_ACTIVE;
                            end
                        end
                        OP_RESPONSE:
                        begin
                            if (auth_reg != AUTH_CHALLENGE)
                            begin
                                status_reg <= ST_NO_CHALLENGE;
                            end
                            hidx_reg <= '0;
                        end
                        OP_QUERY:
                        begin
                            if (!active_reg || auth_reg != AUTH_OK)
                            begin
                                status_reg <= ST_NOT_AUTH;
                            end
                            else if (expired_reg)
                            begin
                                auth_reg   <= AUTH_EXPIRED;
                                active_reg <= 1'b0;
                                status_reg <= ST_EXPIRED;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DRAW:
                begin
                    gen_reg             <= draw_val;
                    nonce_reg[nidx_reg] <= draw_val[7:0];
                    nidx_reg            <= nidx_reg + NIDX_W'(1);
                end
                S_HASH:
                begin
                    // Fold each finished segment hash into the running xor
                    if (hidx_reg == HIDX_W'(0))
                    begin
                        xsum_reg <= '0;
                    end
                    else if (hash_seed)
                    begin
                        xsum_reg <= xsum_reg ^ hash_val;
                    end
                    hidx_reg <= hidx_reg + HIDX_W'(1);
                end
                S_VERIFY:
                begin
                    if (cmd_reg.response == expected)
                    begin
                        auth_reg <= AUTH_OK;
                        fail_reg <= '0;
                    end
                    else
                    begin
                        fail_reg <= fail_inc;
                        if (fail_inc >= max_attempts_reg)
                        begin
                            auth_reg   <= AUTH_LOCKED;
                            active_reg <= 1'b0;
                            wipe_reg   <= (sec_level_reg >= SEC_WIPE_LEVEL);
                            status_reg <= ST_LOCKED_OUT;
                        end
                        else
                        begin
                            status_reg <= ST_MISMATCH;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Pack the nonce bytes; bytes past the nonce length read as zero
    for (genvar g = 0; g < 8; g++)
    begin : g_nonce_pack
        if (g < NONCE_BYTES)
        begin : g_hi
            assign nonce_hi[63 - 8*g -: 8] = nonce_reg[g];
        end
        else
        begin : g_hi_zero
            assign nonce_hi[63 - 8*g -: 8] = 8'd0;
        end
        if (g + 8 < NONCE_BYTES)
        begin : g_lo
            assign nonce_lo[63 - 8*g -: 8] = nonce_reg[g + 8];
        end
        else
        begin : g_lo_zero
            assign nonce_lo[63 - 8*g -: 8] = 8'd0;
        end
    end

    // Drive the result word
    assign done                  = (state_reg == S_REPLY);
    assign result.status         = status_reg;
    assign result.auth_state     = auth_reg;
    assign result.session_active = active_reg;
    assign result.failed_count   = fail_reg;
    assign result.challenge_out  = challenge_reg;
    assign result.nonce_high     = nonce_hi;
    assign result.nonce_low      = nonce_lo;
    assign result.wipe_keys      = wipe_reg;

    // One result word per command, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted command keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after accept");

    // Key wipe only comes with a lockout that ended the session
    a_wipe_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.wipe_keys) |->
            (result.status == ST_LOCKED_OUT && !result.session_active))
        else $error("wipe without lockout");

    // A live session is either challenged or authenticated
    a_active_state: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.session_active) |->
            (result.auth_state == AUTH_CHALLENGE || result.auth_state == AUTH_OK))
        else $error("active session in locked or expired state");

endmodule

>>> src/cral_fnv_unit.sv
// Shared FNV-1a-32 byte unit: one multiply-by-prime step per cycle while en is high.
// Depends on cral_pkg for the basis, prime and step function.
module cral_fnv_unit
    import cral_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic        seed,
    input  logic [7:0]  data,
    output logic [31:0] hash
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;

    // Restart from the basis at a segment head, else chain on the running hash
    always_comb
    begin
        acc_next = fnv_step(seed ? FNV_BASIS : acc_reg, data);
    end

    // Hold the running hash between steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign hash = acc_reg;

endmodule

>>> bench/cral_session_checker.sv
`timescale 1ns / 1ps
// Session checker for the challenge-response authenticator: watches the command,
// result and register ports, predicts every result and compares it. Uses cral_pkg.
module cral_session_checker
    import cral_pkg::*;
#(
    parameter int NONCE_BYTES      = DEF_NONCE_BYTES,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  cral_in_t               cmd,
    input  logic                   done,
    input  cral_out_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     replies_owed,
    output int                     mismatches,
    output int                     compared,
    output logic [31:0]            right_response
);

    // Register copies
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [7:0]  max_att;
    logic [15:0] timeout_s;
    logic [1:0]  level;

    // Session state
    logic [31:0] clock_ticks;
    logic [31:0] opened_at;
    auth_e       session;
    logic        live;
    logic [7:0]  misses;
    logic [31:0] challenge;
    logic [7:0]  nonce [16];
    logic [31:0] stir_reg;

    cral_out_t   replies_due [$];

    function automatic logic [31:0] fnv_absorb(logic [31:0] h, logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    // Response word that the current challenge, key and nonce call for
    function automatic logic [31:0] accepted_response();
        logic [31:0] hc;
        logic [31:0] hk;
        logic [31:0] hn;
        hc = FNV_BASIS;
        hk = FNV_BASIS;
        hn = FNV_BASIS;
        for (int i = 0; i < 4; i++)
            hc = fnv_absorb(hc, challenge[31-8*i -: 8]);
        for (int i = 0; i < 8; i++)
            hk = fnv_absorb(hk, key_hi[63-8*i -: 8]);
        for (int i = 0; i < 8; i++)
            hk = fnv_absorb(hk, key_lo[63-8*i -: 8]);
        for (int i = 0; i < NONCE_BYTES && i < 16; i++)
            hn = fnv_absorb(hn, nonce[i]);
        return hc ^ hk ^ hn;
    endfunction

    // Session lifetime used up; the limit product wraps at 32 bits
    function automatic bit lapsed();
        logic [31:0] span;
        logic [31:0] limit;
        span  = clock_ticks - opened_at;
        limit = 32'(timeout_s) * 32'(TICKS_PER_SECOND);
        return span >= limit;
    endfunction

    // Stir the generator with both samples, then shift in the feedback tap
    task automatic draw_word(input logic [15:0] timer, input logic [9:0] adc,
                             output logic [31:0] w);
        logic [31:0] s;
        logic        fb;
        s        = stir_reg ^ {16'd0, timer} ^ {22'd0, adc};
        fb       = s[0] ^ s[2] ^ s[3] ^ s[5];
        stir_reg = {fb, s[31:1]};
        w        = stir_reg;
    endtask

    task automatic close_session();
        live      = 1'b0;
        session   = AUTH_LOCKED;
        challenge = '0;
        for (int i = 0; i < 16; i++)
            nonce[i] = '0;
    endtask

    // Apply one command word to the session and build the result it reports
    task automatic run_command(input cral_in_t w, output cral_out_t r);
        status_e     st;
        logic        wipe;
        logic [31:0] draw;
        logic [63:0] hi;
        logic [63:0] lo;
        st   = ST_OK;
        wipe = 1'b0;
        case (w.op)
            OP_TICK:
            begin
                clock_ticks = clock_ticks + 32'd1;
                if (live && lapsed())
                    close_session();
            end
            OP_START:
            begin
                if (live && !lapsed())
                    st = ST_ACTIVE;
                else
                begin
                    draw_word(w.timer_sample, w.adc_sample, challenge);
                    session   = AUTH_CHALLENGE;
                    opened_at = clock_ticks;
                    misses    = '0;
                    live      = 1'b1;
                    for (int i = 0; i < NONCE_BYTES && i < 16; i++)
                    begin
                        draw_word(w.timer_sample, w.adc_sample, draw);
                        nonce[i] = draw[7:0];
                    end
                end
            end
            OP_RESPONSE:
            begin
                if (session != AUTH_CHALLENGE)
                    st = ST_NO_CHALLENGE;
                else if (w.response == accepted_response())
                begin
                    session = AUTH_OK;
                    misses  = '0;
                end
                else
                begin
                    if (misses != FAIL_SAT)
                        misses = misses + 8'd1;
                    // lockout keeps challenge and nonce
                    if (misses >= max_att)
                    begin
                        session = AUTH_LOCKED;
                        live    = 1'b0;
                        wipe    = (level >= SEC_WIPE_LEVEL);
                        st      = ST_LOCKED_OUT;
                    end
                    else
                        st = ST_MISMATCH;
                end
            end
            OP_END:
                close_session();
            OP_QUERY:
            begin
                if (!live || session != AUTH_OK)
                    st = ST_NOT_AUTH;
                else if (lapsed())
                begin
                    session = AUTH_EXPIRED;
                    live    = 1'b0;
                    st      = ST_EXPIRED;
                end
            end
            default: ;
        endcase

        // Pack the nonce, bytes beyond the nonce length read as zero
        hi = '0;
        lo = '0;
        for (int i = 0; i < 8; i++)
        begin
            hi = {hi[55:0], (i < NONCE_BYTES) ? nonce[i] : 8'd0};
            lo = {lo[55:0], (i + 8 < NONCE_BYTES) ? nonce[i+8] : 8'd0};
        end

        r.status         = st;
        r.auth_state     = session;
        r.session_active = live;
        r.failed_count   = misses;
        r.challenge_out  = challenge;
        r.nonce_high     = hi;
        r.nonce_low      = lo;
        r.wipe_keys      = wipe;
    endtask

    function automatic int field_differs(string label, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        return 1;
    endfunction

    // Track registers, predict on each accepted word, compare on each strobe
    always @(posedge clk or negedge rst_n)
    begin
        cral_out_t want;
        cral_out_t reply;
        if (!rst_n)
        begin
            key_hi       = '0;
            key_lo       = '0;
            max_att      = RST_MAX_ATTEMPTS;
            timeout_s    = RST_TIMEOUT;
            level        = RST_SEC_LEVEL;
            clock_ticks  = '0;
            opened_at    = '0;
            live         = 1'b0;
            misses       = '0;
            stir_reg     = GEN_SEED;
            close_session();
            replies_due.delete();
            replies_owed = 0;
            mismatches   = 0;
            compared     = 0;
            right_response = accepted_response();
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (reg_index_e'(cfg_index))
                    REG_KEY_HIGH:     key_hi    = cfg_data;
                    REG_KEY_LOW:      key_lo    = cfg_data;
                    REG_MAX_ATTEMPTS: max_att   = cfg_data[7:0];
                    REG_TIMEOUT:      timeout_s = cfg_data[15:0];
                    REG_SEC_LEVEL:    level     = cfg_data[1:0];
                    default: ;
                endcase
            end

            if (done === 1'b1)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: result with no command waiting, got %0h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    compared++;
                    mismatches += field_differs("status", want.status, result.status);
                    mismatches += field_differs("auth_state", want.auth_state,
                                                result.auth_state);
                    mismatches += field_differs("session_active", want.session_active,
                                                result.session_active);
                    mismatches += field_differs("failed_count", want.failed_count,
                                                result.failed_count);
                    mismatches += field_differs("challenge_out", want.challenge_out,
                                                result.challenge_out);
                    mismatches += field_differs("nonce_high", want.nonce_high,
                                                result.nonce_high);
                    mismatches += field_differs("nonce_low", want.nonce_low,
                                                result.nonce_low);
                    mismatches += field_differs("wipe_keys", want.wipe_keys,
                                                result.wipe_keys);
                end
            end

            if (start === 1'b1 && busy === 1'b0)
            begin
                run_command(cmd, reply);
                replies_due.push_back(reply);
            end

            replies_owed   = replies_due.size();
            right_response = accepted_response();
        end
    end

endmodule

>>> bench/challenge_response_auth_lockout_top_test.sv
`timescale 1ns / 1ps
// Top of the authenticator testbench: clock, reset, command and register stimulus,
// watchdog and verdict. Needs cral_pkg, the block and cral_session_checker.
module challenge_response_auth_lockout_top_test
    import cral_pkg::*;
();

    // First op code with no operation behind it; codes up to 7 are spare
    localparam logic [2:0] OP_SPARE    = 3'd5;
    localparam int         STALL_LIMIT = 4000;
    localparam int         DRAIN_WAIT  = 60;

    typedef enum {AIM_ANY, AIM_RIGHT, AIM_WRONG} aim_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    cral_in_t               cmd = '0;
    logic                   done;
    cral_out_t              result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          replies_owed;
    int          mismatches;
    int          compared;
    logic [31:0] right_response;

    int issued = 0;
    int settings = 0;
    int gap_max = 14;
    int stalled = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    challenge_response_auth_lockout_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cral_session_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .done           (done),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .replies_owed   (replies_owed),
        .mismatches     (mismatches),
        .compared       (compared),
        .right_response (right_response)
    );

    // Drop the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stalled <= 0;
            else
                stalled <= stalled + 1;
            if (stalled >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic cral_in_t word_of(logic [2:0] op, logic [31:0] resp,
                                         logic [15:0] timer, logic [9:0] adc);
        cral_in_t w;
        w.op           = op;
        w.response     = resp;
        w.timer_sample = timer;
        w.adc_sample   = adc;
        return w;
    endfunction

    function automatic cral_in_t any_word(logic [2:0] op);
        return word_of(op, 32'($urandom), 16'($urandom), 10'($urandom_range(0, 1023)));
    endfunction

    // Idle a random number of cycles, then hold start until the word is taken.
    // A right or wrong response never goes out without an idle gap after the last word,
    // so that the predicted answer is settled.
    task automatic issue(input cral_in_t w, input aim_e aim);
        int          gap;
        logic [31:0] flip;
        gap = $urandom_range(0, gap_max);
        if (aim != AIM_ANY && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (aim == AIM_RIGHT)
            w.response = right_response;
        else if (aim == AIM_WRONG)
        begin
            flip = $urandom;
            if (flip == 0)
                flip = 32'h8000_0000;
            w.response = right_response ^ flip;
        end
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        issued++;
    endtask

    // Release start and wait for every predicted result to arrive
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (replies_owed != 0);
        @(posedge clk);
    endtask

    task automatic poke(input reg_index_e idx, input logic [63:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Write the full register set while the block is idle
    task automatic load_regs(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [7:0] ma, input logic [15:0] tmo,
                             input logic [1:0] lv);
        drain();
        poke(REG_KEY_HIGH, kh);
        poke(REG_KEY_LOW, kl);
        poke(REG_MAX_ATTEMPTS, 64'(ma));
        poke(REG_TIMEOUT, 64'(tmo));
        poke(REG_SEC_LEVEL, 64'(lv));
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Random command mix; grinding piles up wrong responses toward lockout
    task automatic run_mix(input int n, input bit grind);
        int         counted;
        int         roll;
        logic [2:0] op;
        aim_e       aim;
        counted = 0;
        while (counted < n)
        begin
            if (counted % 40 == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            roll = $urandom_range(0, 99);
            aim  = AIM_ANY;
            if (grind)
            begin
                if (roll < 3)
                    op = OP_TICK;
                else if (roll < 6)
                    op = OP_QUERY;
                else if (roll < 9)
                    op = OP_START;
                else
                begin
                    op  = OP_RESPONSE;
                    aim = AIM_WRONG;
                end
            end
            else
            begin
                if (roll < 10)
                    op = OP_TICK;
                else if (roll < 25)
                    op = OP_START;
                else if (roll < 50)
                begin
                    op  = OP_RESPONSE;
                    aim = AIM_RIGHT;
                end
                else if (roll < 62)
                begin
                    op  = OP_RESPONSE;
                    aim = AIM_WRONG;
                end
                else if (roll < 66)
                    op = OP_RESPONSE;
                else if (roll < 76)
                    op = OP_END;
                else if (roll < 95)
                    op = OP_QUERY;
                else
                    op = 3'(OP_SPARE + $urandom_range(0, 2));
            end
            issue(any_word(op), aim);
            if (op < OP_SPARE)
                counted++;
        end
        gap_max = 14;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: queries, responses, spare ops and a tick with no session
        issue(word_of(OP_QUERY, 32'h0, 16'h0, 10'h0), AIM_ANY);
        issue(word_of(OP_RESPONSE, 32'h0, 16'h0, 10'h0), AIM_ANY);
        for (int k = 0; k < 3; k++)
            issue(any_word(3'(OP_SPARE + k)), AIM_ANY);
        issue(any_word(OP_TICK), AIM_ANY);

        // Full session: start at sample extremes, repeat start, fail once, pass, query, end
        issue(word_of(OP_START, 32'hffff_ffff, 16'hffff, 10'h3ff), AIM_ANY);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_QUERY), AIM_ANY);
        issue(any_word(OP_RESPONSE), AIM_WRONG);
        issue(any_word(OP_RESPONSE), AIM_RIGHT);
        issue(any_word(OP_QUERY), AIM_ANY);
        issue(word_of(OP_RESPONSE, 32'hffff_ffff, 16'h0, 10'h0), AIM_ANY);
        issue(any_word(OP_END), AIM_ANY);

        // Lockout below the wipe level, then a response with no challenge
        issue(word_of(OP_START, 32'h0, 16'h0, 10'h0), AIM_ANY);
        repeat (3) issue(any_word(OP_RESPONSE), AIM_WRONG);
        issue(any_word(OP_RESPONSE), AIM_RIGHT);

        // Zero attempts and zero timeout at the top level
        load_regs(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd0, 16'd0, 2'd3);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_RESPONSE), AIM_WRONG);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_RESPONSE), AIM_RIGHT);
        issue(any_word(OP_QUERY), AIM_ANY);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_TICK), AIM_ANY);

        // Single attempt with the longest timeout
        load_regs({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                  8'd1, 16'hffff, 2'd2);
        issue(any_word(OP_START), AIM_ANY);
        issue(any_word(OP_RESPONSE), AIM_WRONG);

        // Random phases over several register settings
        load_regs({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                  8'd3, 16'd300, 2'd2);
        run_mix(150, 1'b0);
        load_regs(64'h0, 64'h0, 8'd0, 16'd0, 2'd0);
        run_mix(120, 1'b0);
        load_regs(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd255, 16'hffff, 2'd3);
        run_mix(300, 1'b1);
        load_regs({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                  8'd1, 16'd1, 2'd1);
        run_mix(140, 1'b0);
        for (int p = 0; p < 3; p++)
        begin
            load_regs({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                      8'($urandom_range(1, 8)), 16'($urandom_range(0, 2)),
                      2'($urandom_range(0, 3)));
            run_mix(80, 1'b0);
        end

        // Let every result arrive, then watch for strays
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run: %0d commands over %0d register settings after reset",
                 issued, settings);
        $display("run: %0d results checked field by field, %0d field errors",
                 compared, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/cral_pkg.sv
src/cral_fnv_unit.sv
src/challenge_response_auth_lockout_top.sv
bench/cral_session_checker.sv
bench/challenge_response_auth_lockout_top_test.sv
